// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, reset included.
`define LMBP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

// Property checked only while reset is released.
`define LMBP_ASSERT_RUN(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/lmbp_pkg.sv =====
package lmbp_pkg;

    localparam int WIDTH_MAX  = 1024;
    localparam int HEIGHT_MAX = 1024;
    localparam int LABEL_BITS = 15;

    // Fixed field widths of the ports.
    localparam int SIZE_W     = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int LABEL_IN_W = 15;

    localparam int ADDR_W     = $clog2(WIDTH_MAX);
    localparam int ROW_CNT_W  = 11;
    localparam int FLUSH_W    = SIZE_W;
    localparam int CELL_W     = LABEL_BITS + 1;

    localparam logic [ROW_CNT_W-1:0] ROW_CAP    = {ROW_CNT_W{1'b1}};
    localparam logic [SIZE_W-1:0]    W_MAX_SIZE = SIZE_W'(WIDTH_MAX);
    localparam logic [SIZE_W-1:0]    H_MAX_SIZE = SIZE_W'(HEIGHT_MAX);
    localparam logic [ADDR_W-1:0]    LAST_ADDR  = ADDR_W'(WIDTH_MAX - 1);

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;
    localparam t_reg_idx REG_CONN   = 2'd2;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd1024;

    // Result queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              conn;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        t_cell             pix;
        logic              decide;
        logic              up;
        logic              down;
        logic              left;
        logic              right;
        logic [COL_W-1:0]  dcol;
        logic [ROW_W-1:0]  drow;
    } t_ctx;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_res;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/lmbp_if.sv =====
interface lmbp_pix_if;
    logic                              valid;
    logic                              ready;
    logic                              occupied;
    logic [lmbp_pkg::LABEL_IN_W-1:0]   label;
    logic                              flush;

    modport source (output valid, output occupied, output label, output flush, input ready);
    modport sink   (input valid, input occupied, input label, input flush, output ready);
endinterface

interface lmbp_res_if;
    logic                         valid;
    logic                         ready;
    logic [lmbp_pkg::COL_W-1:0]   column;
    logic [lmbp_pkg::ROW_W-1:0]   row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

// ===== rtl/core/label_map_boundary_pixels_unit.sv =====
// A boundary pixel passes the context register and the result queue on its way to o_res.
// A pixel is decided by the input transaction frame_width+1 positions after its own.
// Throughput: one input transaction per cycle while i_pix.ready is high, limited by the single
// read and write port of each line buffer; the result queue holds four entries.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 1024 line buffer
// entries, during which i_pix.ready stays low (configuration writes are taken as usual).
module label_map_boundary_pixels_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lmbp_pix_if.sink                      i_pix,
    lmbp_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmbp_pkg::PDATA_W-1:0]  pwdata,
    output logic [lmbp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    lmbp_pkg::t_cfg                 cfg;
    lmbp_pkg::t_ctx                 ctx;
    logic [lmbp_pkg::ADDR_W-1:0]    rd_addr;
    lmbp_pkg::t_cell                upper_rd, mid_rd;
    lmbp_pkg::t_cell                wr_upper, wr_mid;
    logic                           clr_busy;
    logic                           push;
    lmbp_pkg::t_res                 push_res;
    lmbp_pkg::t_res                 head;
    logic [lmbp_pkg::OQ_CNT_W-1:0]  oq_count;
    logic                           accept;
    logic                           pop;

    // Register file. The sizes leave it already clamped to the legal range.
    lmbp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // An item may enter, once the clearing pass is over, whenever the result queue has room for
    // everything in flight: the entries it holds, the item in the decision stage and the new item
    // itself. The decision is made in the cycle after acceptance, so no stall ever reaches
    // the line buffers or the window.
    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !clr_busy
                      && ((oq_count + lmbp_pkg::OQ_CNT_W'(ctx.valid))
                          < lmbp_pkg::OQ_CNT_W'(lmbp_pkg::OQ_DEPTH));

    // Input stage: raster position, flush counting and the geometry of the pixel that
    // this transaction decides. It issues the line buffer read and registers the context.
    lmbp_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_occupied (i_pix.occupied),
        .i_label    (i_pix.label),
        .i_flush    (i_pix.flush),
        .i_cfg      (cfg),
        .o_rd_addr  (rd_addr),
        .o_ctx      (ctx)
    );

    // Two line buffers with registered reads. The write of the decision stage goes to the
    // column read in the previous cycle; when the frame is one pixel wide the next read hits
    // the same column, and the line buffer forwards the fresh data.
    lmbp_line_buf u_line_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .i_wr_en    (ctx.valid),
        .i_wr_addr  (ctx.addr),
        .i_wr_upper (wr_upper),
        .i_wr_mid   (wr_mid),
        .o_upper    (upper_rd),
        .o_mid      (mid_rd),
        .o_busy     (clr_busy)
    );

    // Decision stage: shift the 3x3 window and compare the centre with its neighbours.
    // Neighbours outside the frame count as different, which also hides stale line data.
    lmbp_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctx      (ctx),
        .i_conn     (cfg.conn),
        .i_upper    (upper_rd),
        .i_mid      (mid_rd),
        .o_push     (push),
        .o_res      (push_res),
        .o_wr_upper (wr_upper),
        .o_wr_mid   (wr_mid)
    );

    // Result queue: decouples the output handshake from the input side.
    assign pop = o_res.valid && o_res.ready;

    lmbp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_res),
        .i_pop   (pop),
        .o_valid (o_res.valid),
        .o_data  (head),
        .o_count (oq_count)
    );

    assign o_res.column = head.column;
    assign o_res.row    = head.row;

endmodule

// ===== rtl/core/lmbp_cfg_regs.sv =====
module lmbp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lmbp_pkg::PDATA_W-1:0]  pwdata,
    output logic [lmbp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output lmbp_pkg::t_cfg                o_cfg
);

    logic [lmbp_pkg::SIZE_W-1:0] r_frame_width;
    logic [lmbp_pkg::SIZE_W-1:0] r_frame_height;
    logic                        r_connectivity;
    lmbp_pkg::t_reg_idx          reg_idx;
    logic                        wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lmbp_pkg::RESET_WIDTH;
            r_frame_height <= lmbp_pkg::RESET_HEIGHT;
            r_connectivity <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                lmbp_pkg::REG_WIDTH:  r_frame_width  <= pwdata[lmbp_pkg::SIZE_W-1:0];
                lmbp_pkg::REG_HEIGHT: r_frame_height <= pwdata[lmbp_pkg::SIZE_W-1:0];
                lmbp_pkg::REG_CONN:   r_connectivity <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lmbp_pkg::REG_WIDTH:  prdata = lmbp_pkg::PDATA_W'(r_frame_width);
            lmbp_pkg::REG_HEIGHT: prdata = lmbp_pkg::PDATA_W'(r_frame_height);
            lmbp_pkg::REG_CONN:   prdata = lmbp_pkg::PDATA_W'(r_connectivity);
            default:              prdata = '0;
        endcase
    end

    // Sizes out of range act as the nearest legal size.
    assign o_cfg.width  = lmbp_pkg::clamp_size(r_frame_width, lmbp_pkg::W_MAX_SIZE);
    assign o_cfg.height = lmbp_pkg::clamp_size(r_frame_height, lmbp_pkg::H_MAX_SIZE);
    assign o_cfg.conn   = r_connectivity;

endmodule

// ===== rtl/core/lmbp_scan.sv =====
module lmbp_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_occupied,
    input  logic [lmbp_pkg::LABEL_IN_W-1:0]  i_label,
    input  logic                             i_flush,
    input  lmbp_pkg::t_cfg                   i_cfg,
    output logic [lmbp_pkg::ADDR_W-1:0]      o_rd_addr,
    output lmbp_pkg::t_ctx                   o_ctx
);

    logic [lmbp_pkg::ADDR_W-1:0]    r_col,  n_col;
    logic [lmbp_pkg::ROW_CNT_W-1:0] r_row,  n_row;
    logic [lmbp_pkg::FLUSH_W-1:0]   r_fcnt, n_fcnt;
    lmbp_pkg::t_ctx                 r_ctx,  n_ctx;

    logic [lmbp_pkg::ADDR_W-1:0]    col_cur;
    logic [lmbp_pkg::ROW_CNT_W-1:0] row_cur;
    logic [lmbp_pkg::SIZE_W-1:0]    col_ext;
    logic [lmbp_pkg::SIZE_W-1:0]    col_inc;
    logic [lmbp_pkg::SIZE_W-1:0]    dcol_w;
    logic [lmbp_pkg::ROW_CNT_W-1:0] drow_w;
    logic [lmbp_pkg::FLUSH_W-1:0]   fcnt_inc;
    logic                           have;

    function automatic logic [lmbp_pkg::ROW_CNT_W-1:0] bump(
        input logic [lmbp_pkg::ROW_CNT_W-1:0] r);
        logic [lmbp_pkg::ROW_CNT_W-1:0] b;
        b = (r < lmbp_pkg::ROW_CAP) ? r + 1'b1 : r;
        return b;
    endfunction

    always_comb begin
        // A column left past the end by a width change moves to the next row.
        if (lmbp_pkg::SIZE_W'(r_col) >= i_cfg.width) begin
            col_cur = '0;
            row_cur = bump(r_row);
        end else begin
            col_cur = r_col;
            row_cur = r_row;
        end
        col_ext = lmbp_pkg::SIZE_W'(col_cur);

        // The pixel decided now sits one row up and one column left, or two rows up at the last column from column 0.
        have   = 1'b0;
        dcol_w = '0;
        drow_w = '0;
        if (col_cur != '0 && row_cur >= lmbp_pkg::ROW_CNT_W'(1)) begin
            have   = 1'b1;
            dcol_w = col_ext - 1'b1;
            drow_w = row_cur - 1'b1;
        end else if (col_cur == '0 && row_cur >= lmbp_pkg::ROW_CNT_W'(2)) begin
            have   = 1'b1;
            dcol_w = i_cfg.width - 1'b1;
            drow_w = row_cur - lmbp_pkg::ROW_CNT_W'(2);
        end

        n_ctx.valid  = i_accept;
        n_ctx.addr   = col_cur;
        n_ctx.pix    = (i_occupied && !i_flush)
                     ? {1'b1, i_label[lmbp_pkg::LABEL_BITS-1:0]} : '0;
        n_ctx.decide = have && (lmbp_pkg::SIZE_W'(drow_w) < i_cfg.height);
        n_ctx.up     = drow_w != '0;
        n_ctx.down   = ({1'b0, drow_w} + 1'b1) < {1'b0, i_cfg.height};
        n_ctx.left   = dcol_w != '0;
        n_ctx.right  = ({1'b0, dcol_w} + 1'b1) < {1'b0, i_cfg.width};
        n_ctx.dcol   = dcol_w[lmbp_pkg::COL_W-1:0];
        n_ctx.drow   = drow_w[lmbp_pkg::ROW_W-1:0];

        // Advance the position.
        col_inc = col_ext + 1'b1;
        if (col_inc >= i_cfg.width) begin
            n_col = '0;
            n_row = bump(row_cur);
        end else begin
            n_col = col_inc[lmbp_pkg::ADDR_W-1:0];
            n_row = row_cur;
        end

        // A run of width+1 flush items ends the frame.
        fcnt_inc = r_fcnt + 1'b1;
        n_fcnt   = '0;
        if (i_flush) begin
            if (fcnt_inc >= (i_cfg.width + 1'b1)) begin
                n_col = '0;
                n_row = '0;
            end else begin
                n_fcnt = fcnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fcnt <= '0;
            r_ctx  <= '0;
        end else begin
            r_ctx <= n_ctx;
            if (i_accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_fcnt <= n_fcnt;
            end
        end
    end

    assign o_rd_addr = col_cur;
    assign o_ctx     = r_ctx;

endmodule

// ===== rtl/core/lmbp_line_buf.sv =====
module lmbp_line_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lmbp_pkg::ADDR_W-1:0]  i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [lmbp_pkg::ADDR_W-1:0]  i_wr_addr,
    input  lmbp_pkg::t_cell              i_wr_upper,
    input  lmbp_pkg::t_cell              i_wr_mid,
    output lmbp_pkg::t_cell              o_upper,
    output lmbp_pkg::t_cell              o_mid,
    output logic                         o_busy
);

    lmbp_pkg::t_cell mem_upper [lmbp_pkg::WIDTH_MAX];
    lmbp_pkg::t_cell mem_mid   [lmbp_pkg::WIDTH_MAX];

    logic                        r_clr_busy;
    logic [lmbp_pkg::ADDR_W-1:0] r_clr_addr;
    logic                        r_hit;
    lmbp_pkg::t_cell             r_upper_q, r_mid_q;
    lmbp_pkg::t_cell             r_byp_upper, r_byp_mid;

    logic                        we;
    logic [lmbp_pkg::ADDR_W-1:0] wa;
    lmbp_pkg::t_cell             wd_upper, wd_mid;

    // The clearing pass owns the write port until it has zeroed every entry.
    assign we       = r_clr_busy || i_wr_en;
    assign wa       = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wd_upper = r_clr_busy ? '0 : i_wr_upper;
    assign wd_mid   = r_clr_busy ? '0 : i_wr_mid;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_upper[wa] <= wd_upper;
            mem_mid[wa]   <= wd_mid;
        end
        r_upper_q   <= mem_upper[i_rd_addr];
        r_mid_q     <= mem_mid[i_rd_addr];
        r_byp_upper <= wd_upper;
        r_byp_mid   <= wd_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_hit      <= 1'b0;
        end else begin
            // A write to the address read in the same cycle is forwarded.
            r_hit <= we && (wa == i_rd_addr);
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == lmbp_pkg::LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_upper = r_hit ? r_byp_upper : r_upper_q;
    assign o_mid   = r_hit ? r_byp_mid   : r_mid_q;
    assign o_busy  = r_clr_busy;

endmodule

// ===== rtl/core/lmbp_window.sv =====
module lmbp_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lmbp_pkg::t_ctx   i_ctx,
    input  logic             i_conn,
    input  lmbp_pkg::t_cell  i_upper,
    input  lmbp_pkg::t_cell  i_mid,
    output logic             o_push,
    output lmbp_pkg::t_res   o_res,
    output lmbp_pkg::t_cell  o_wr_upper,
    output lmbp_pkg::t_cell  o_wr_mid
);

    lmbp_pkg::t_cell r_win [9];
    lmbp_pkg::t_cell n_win [9];
    logic [8:0]      eq;
    logic            inner4, inner_diag, inner;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = i_upper;
        n_win[5] = i_mid;
        n_win[8] = i_ctx.pix;

        for (int i = 0; i < 9; i++) begin
            eq[i] = n_win[i] == n_win[4];
        end

        inner4 = (i_ctx.right && eq[5]) && (i_ctx.left && eq[3])
              && (i_ctx.up && eq[1]) && (i_ctx.down && eq[7]);
        inner_diag = (i_ctx.up && i_ctx.left && eq[0]) && (i_ctx.down && i_ctx.right && eq[8])
                  && (i_ctx.up && i_ctx.right && eq[2]) && (i_ctx.down && i_ctx.left && eq[6]);
        inner = inner4 && (!i_conn || inner_diag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctx.valid) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    assign o_push     = i_ctx.valid && i_ctx.decide && n_win[4][lmbp_pkg::CELL_W-1] && !inner;
    assign o_res.column = i_ctx.dcol;
    assign o_res.row    = i_ctx.drow;
    assign o_wr_upper = i_mid;
    assign o_wr_mid   = i_ctx.pix;

endmodule

// ===== rtl/core/lmbp_out_fifo.sv =====
module lmbp_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  lmbp_pkg::t_res                 i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output lmbp_pkg::t_res                 o_data,
    output logic [lmbp_pkg::OQ_CNT_W-1:0]  o_count
);

    lmbp_pkg::t_res                r_mem [lmbp_pkg::OQ_DEPTH];
    logic [lmbp_pkg::OQ_PTR_W-1:0] r_wp, r_rp;
    logic [lmbp_pkg::OQ_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ===== rtl/core/lmbp_checker.sv =====
`include "assert_macros.svh"

module lmbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lmbp_pkg::COL_W-1:0]    i_out_column,
    input logic [lmbp_pkg::ROW_W-1:0]    i_out_row,
    input logic                          i_psel,
    input logic                          i_penable,
    input logic                          i_pwrite,
    input logic [lmbp_pkg::PADDR_W-1:0]  i_paddr,
    input logic [lmbp_pkg::PDATA_W-1:0]  i_pwdata,
    input logic [lmbp_pkg::PDATA_W-1:0]  i_prdata
);

    // The line buffers are cleared after reset, so no pixel may enter right away.
    `LMBP_ASSERT_ALWAYS(a_no_accept_after_reset, (!i_rst_n |=> !i_in_ready), "input ready right after reset")

    // Reset empties the result queue.
    `LMBP_ASSERT_ALWAYS(a_no_result_after_reset, (!i_rst_n |=> !i_out_valid), "result offered right after reset")

    `LMBP_ASSERT_RUN(a_out_hold, (i_out_valid && !i_out_ready |=> i_out_valid), "result withdrawn before it was taken")

    `LMBP_ASSERT_RUN(a_out_stable, (i_out_valid && !i_out_ready |=> $stable(i_out_column) && $stable(i_out_row)), "stalled result changed")

    // A connectivity write reads back in the next cycle.
    `LMBP_ASSERT_RUN(a_conn_readback, (i_psel && i_penable && i_pwrite && i_paddr[3:2] == lmbp_pkg::REG_CONN |=> !(i_paddr[3:2] == lmbp_pkg::REG_CONN) || i_prdata[0] == $past(i_pwdata[0])), "connectivity readback mismatch")

endmodule

bind label_map_boundary_pixels_unit lmbp_checker u_lmbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_column (o_res.column),
    .i_out_row    (o_res.row),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata)
);
